// ===== rtl/core/bhcr_pkg.sv =====
// shared types, constants and commutation tables for the hall commutation block
// no dependencies
`timescale 1ns / 1ps

package bhcr_pkg;

  localparam int DutyBits = 16;
  localparam int RampBits = 8;
  localparam int HallBits = 3;
  localparam int StepBits = 3;
  localparam int CfgIdxBits = 2;
  // target duty is the widest register
  localparam int CfgDataBits = DutyBits;

  localparam logic [RampBits-1:0] RampIntervalReset = RampBits'(100);

  typedef enum logic [CfgIdxBits-1:0] {
    CfgTargetDuty   = 2'd0,
    CfgReverseDir   = 2'd1,
    CfgRampInterval = 2'd2
  } cfg_idx_e;

  // drive pair codes: high-side phase then low-side phase
  localparam logic [StepBits-1:0] StepNone = 3'd0;
  localparam logic [StepBits-1:0] StepAB   = 3'd1;
  localparam logic [StepBits-1:0] StepAC   = 3'd2;
  localparam logic [StepBits-1:0] StepBC   = 3'd3;
  localparam logic [StepBits-1:0] StepBA   = 3'd4;
  localparam logic [StepBits-1:0] StepCA   = 3'd5;
  localparam logic [StepBits-1:0] StepCB   = 3'd6;

  typedef struct packed {
    logic [DutyBits-1:0] duty_a;
    logic [DutyBits-1:0] duty_b;
    logic [DutyBits-1:0] duty_c;
    logic                low_a;
    logic                low_b;
    logic                low_c;
    logic                code_valid;
    logic [DutyBits-1:0] duty_now;
  } res_t;

  // clockwise drive pair per hall code, StepNone for codes 0 and 7
  function automatic logic [StepBits-1:0] cw_step(input logic [HallBits-1:0] code);
    logic [StepBits-1:0] s;
    unique case (code)
      3'd1:    s = StepAC;
      3'd2:    s = StepBA;
      3'd3:    s = StepBC;
      3'd4:    s = StepCB;
      3'd5:    s = StepAB;
      3'd6:    s = StepCA;
      default: s = StepNone;
    endcase
    return s;
  endfunction

  // counter-clockwise swaps high and low phase
  function automatic logic [StepBits-1:0] rev_step(input logic [StepBits-1:0] s);
    logic [StepBits-1:0] r;
    unique case (s)
      StepAB:  r = StepBA;
      StepAC:  r = StepCA;
      StepBC:  r = StepCB;
      StepBA:  r = StepAB;
      StepCA:  r = StepAC;
      StepCB:  r = StepBC;
      default: r = StepNone;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/bhcr_commutator.sv =====
// duty ramp, configuration registers and six-step drive selection
// depends on bhcr_pkg
`timescale 1ns / 1ps

module bhcr_commutator import bhcr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i,
  input  logic                  fire_i,
  input  logic [HallBits-1:0]   hall_code_i,
  output res_t                  res_o
);

  logic [DutyBits-1:0] target_q, target_d;
  logic                reverse_q, reverse_d;
  logic [RampBits-1:0] interval_q, interval_d;
  logic [DutyBits-1:0] level_q, level_d;
  logic [RampBits-1:0] count_q, count_d;
  logic [StepBits-1:0] step_q, step_d;
  logic [DutyBits-1:0] held_duty_q, held_duty_d;
  logic [StepBits-1:0] new_step;
  logic                code_ok;

  always_comb begin
    target_d   = target_q;
    reverse_d  = reverse_q;
    interval_d = interval_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTargetDuty:   target_d   = cfg_wdata_i[DutyBits-1:0];
        CfgReverseDir:   reverse_d  = cfg_wdata_i[0];
        CfgRampInterval: interval_d = cfg_wdata_i[RampBits-1:0];
        default: ;
      endcase
    end
  end

  // ramp: slow climb by counted events, fast descent of one per event
  always_comb begin
    level_d = level_q;
    count_d = count_q;
    if (level_q < target_q) begin
      if (count_q == interval_q) begin
        level_d = level_q + DutyBits'(1);
        count_d = '0;
      end else begin
        count_d = count_q + RampBits'(1);
      end
    end else if (level_q > target_q) begin
      level_d = level_q - DutyBits'(1);
    end
  end

  always_comb begin
    new_step = cw_step(hall_code_i);
    code_ok  = (new_step != StepNone);
    if (reverse_q) new_step = rev_step(new_step);
    step_d      = code_ok ? new_step : step_q;
    held_duty_d = code_ok ? level_d : held_duty_q;
  end

  always_comb begin
    res_o            = '0;
    res_o.code_valid = code_ok;
    res_o.duty_now   = level_d;
    unique case (step_d)
      StepAB:  begin res_o.duty_a = held_duty_d; res_o.low_b = 1'b1; end
      StepAC:  begin res_o.duty_a = held_duty_d; res_o.low_c = 1'b1; end
      StepBC:  begin res_o.duty_b = held_duty_d; res_o.low_c = 1'b1; end
      StepBA:  begin res_o.duty_b = held_duty_d; res_o.low_a = 1'b1; end
      StepCA:  begin res_o.duty_c = held_duty_d; res_o.low_a = 1'b1; end
      StepCB:  begin res_o.duty_c = held_duty_d; res_o.low_b = 1'b1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      reverse_q   <= 1'b0;
      interval_q  <= RampIntervalReset;
      level_q     <= '0;
      count_q     <= '0;
      step_q      <= StepNone;
      held_duty_q <= '0;
    end else begin
      target_q   <= target_d;
      reverse_q  <= reverse_d;
      interval_q <= interval_d;
      if (fire_i) begin
        level_q     <= level_d;
        count_q     <= count_d;
        step_q      <= step_d;
        held_duty_q <= held_duty_d;
      end
    end
  end

endmodule

// ===== rtl/core/bldc_hall_commutation_ramp.sv =====
// top level: hall event channel, result buffer with skid stage
// depends on bhcr_pkg and bhcr_commutator
`timescale 1ns / 1ps

// each accepted event's result is registered, in the skid stage on a stall
// throughput: one event per cycle, set by the single pass through the ramp and
//   drive table ahead of the result register, while the one-result skid is empty
// reset: duty level, ramp counter and held drive clear to zero (all phases off),
//   ramp interval resets to 100, target and direction to zero, buffers empty

module bldc_hall_commutation_ramp import bhcr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [HallBits-1:0]    hall_code_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [DutyBits-1:0]    duty_a_o,
  output logic [DutyBits-1:0]    duty_b_o,
  output logic [DutyBits-1:0]    duty_c_o,
  output logic                   low_a_o,
  output logic                   low_b_o,
  output logic                   low_c_o,
  output logic                   code_valid_o,
  output logic [DutyBits-1:0]    duty_now_o
);

  res_t res;
  res_t main_q, main_d, skid_q, skid_d;
  logic main_valid_q, main_valid_d, skid_valid_q, skid_valid_d;
  logic fire, take;

  assign in_stall_o = skid_valid_q;
  assign fire       = in_valid_i & ~skid_valid_q;
  assign take       = main_valid_q & ~out_stall_i;

  bhcr_commutator u_comm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .hall_code_i (hall_code_i),
    .res_o       (res)
  );

  always_comb begin
    main_valid_d = main_valid_q;
    main_d       = main_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (take || !main_valid_q) begin
      if (skid_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = fire;
        main_d       = res;
      end
    end else if (fire) begin
      // result still stalled, park the new one
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_valid_o  = main_valid_q;
  assign duty_a_o     = main_q.duty_a;
  assign duty_b_o     = main_q.duty_b;
  assign duty_c_o     = main_q.duty_c;
  assign low_a_o      = main_q.low_a;
  assign low_b_o      = main_q.low_b;
  assign low_c_o      = main_q.low_c;
  assign code_valid_o = main_q.code_valid;
  assign duty_now_o   = main_q.duty_now;

endmodule

// ===== sim/bhcr_drive_checker.sv =====
// drive checker: watches config, request and result channels, predicts each
// commutation result and compares it field by field; depends on bhcr_pkg
`timescale 1ns / 1ps

module bhcr_drive_checker import bhcr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [HallBits-1:0]    hall_code_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [DutyBits-1:0]    duty_a_i,
  input  logic [DutyBits-1:0]    duty_b_i,
  input  logic [DutyBits-1:0]    duty_c_i,
  input  logic                   low_a_i,
  input  logic                   low_b_i,
  input  logic                   low_c_i,
  input  logic                   code_valid_i,
  input  logic [DutyBits-1:0]    duty_now_i,
  output int                     fail_cnt_o,
  output int                     pending_o
);

  // shadow of the configuration registers
  logic [DutyBits-1:0] tgt_duty;
  logic                rev_dir;
  logic [RampBits-1:0] ramp_ival;

  // shadow of the ramp and the held drive
  logic [DutyBits-1:0] level;
  logic [RampBits-1:0] ramp_cnt;
  logic [StepBits-1:0] drive_step;
  logic [DutyBits-1:0] drive_duty;

  res_t drive_q[$];
  res_t want;
  int   errs;

  function automatic logic [StepBits-1:0] hall_to_step(input logic [HallBits-1:0] code,
                                                       input logic rev);
    logic [StepBits-1:0] s;
    case (code)
      3'd5:    s = rev ? StepBA : StepAB;
      3'd1:    s = rev ? StepCA : StepAC;
      3'd3:    s = rev ? StepCB : StepBC;
      3'd2:    s = rev ? StepAB : StepBA;
      3'd6:    s = rev ? StepAC : StepCA;
      3'd4:    s = rev ? StepBC : StepCB;
      default: s = StepNone;
    endcase
    return s;
  endfunction

  // one hall event: ramp first, then table lookup or hold
  function automatic res_t next_drive(input logic [HallBits-1:0] code);
    res_t                r;
    logic [StepBits-1:0] s;
    if (level < tgt_duty) begin
      if (ramp_cnt == ramp_ival) begin
        level    = level + 1'b1;
        ramp_cnt = '0;
      end else begin
        ramp_cnt = ramp_cnt + 1'b1;
      end
    end else if (level > tgt_duty) begin
      level = level - 1'b1;
    end
    s = hall_to_step(code, rev_dir);
    if (s != StepNone) begin
      drive_step = s;
      drive_duty = level;
    end
    r = '0;
    case (drive_step)
      StepAB: begin
        r.duty_a = drive_duty;
        r.low_b  = 1'b1;
      end
      StepAC: begin
        r.duty_a = drive_duty;
        r.low_c  = 1'b1;
      end
      StepBC: begin
        r.duty_b = drive_duty;
        r.low_c  = 1'b1;
      end
      StepBA: begin
        r.duty_b = drive_duty;
        r.low_a  = 1'b1;
      end
      StepCA: begin
        r.duty_c = drive_duty;
        r.low_a  = 1'b1;
      end
      StepCB: begin
        r.duty_c = drive_duty;
        r.low_b  = 1'b1;
      end
      default: ;
    endcase
    r.code_valid = (s != StepNone);
    r.duty_now   = level;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [DutyBits-1:0] exp_v,
                             input logic [DutyBits-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_duty   = '0;
      rev_dir    = 1'b0;
      ramp_ival  = RampIntervalReset;
      level      = '0;
      ramp_cnt   = '0;
      drive_step = StepNone;
      drive_duty = '0;
      errs       = 0;
      drive_q.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgTargetDuty:   tgt_duty  = cfg_wdata_i[DutyBits-1:0];
          CfgReverseDir:   rev_dir   = cfg_wdata_i[0];
          CfgRampInterval: ramp_ival = cfg_wdata_i[RampBits-1:0];
          default: ;
        endcase
      end
      // check before pushing so a stray result is never matched to this edge's request
      if (out_valid_i && !out_stall_i) begin
        if (drive_q.size() == 0) begin
          $display("%0t ns: result with no request outstanding, duty_now %0d", $time,
                   duty_now_i);
          errs++;
        end else begin
          want = drive_q.pop_front();
          check_field("duty_a", want.duty_a, duty_a_i);
          check_field("duty_b", want.duty_b, duty_b_i);
          check_field("duty_c", want.duty_c, duty_c_i);
          check_field("low_a", DutyBits'(want.low_a), DutyBits'(low_a_i));
          check_field("low_b", DutyBits'(want.low_b), DutyBits'(low_b_i));
          check_field("low_c", DutyBits'(want.low_c), DutyBits'(low_c_i));
          check_field("code_valid", DutyBits'(want.code_valid), DutyBits'(code_valid_i));
          check_field("duty_now", want.duty_now, duty_now_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        drive_q.push_back(next_drive(hall_code_i));
      end
      fail_cnt_o <= errs;
      pending_o  <= drive_q.size();
    end
  end

endmodule

// ===== sim/bldc_hall_commutation_ramp_tb.sv =====
// testbench top: clock, reset, hall event stimulus, config phases and result stalls
// depends on bhcr_pkg, bldc_hall_commutation_ramp and bhcr_drive_checker
`timescale 1ns / 1ps

module bldc_hall_commutation_ramp_tb;
  import bhcr_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 400;
  localparam logic [HallBits-1:0]   HallLow  = 3'd0;
  localparam logic [HallBits-1:0]   HallHigh = 3'd7;
  localparam logic [CfgIdxBits-1:0] CfgSpare = 2'd3;
  localparam logic [DutyBits-1:0]   DutyMax  = '1;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx = CfgTargetDuty;
  logic [CfgDataBits-1:0] cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [HallBits-1:0]    hall_code = HallLow;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [DutyBits-1:0]    duty_a, duty_b, duty_c, duty_now;
  logic                   low_a, low_b, low_c, code_valid;
  int                     fail_cnt;
  int                     pending;
  int                     cyc = 0;
  logic [DutyBits-1:0]    last_level = '0;

  bldc_hall_commutation_ramp u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .hall_code_i  (hall_code),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .duty_a_o     (duty_a),
    .duty_b_o     (duty_b),
    .duty_c_o     (duty_c),
    .low_a_o      (low_a),
    .low_b_o      (low_b),
    .low_c_o      (low_c),
    .code_valid_o (code_valid),
    .duty_now_o   (duty_now)
  );

  bhcr_drive_checker u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .hall_code_i  (hall_code),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .duty_a_i     (duty_a),
    .duty_b_i     (duty_b),
    .duty_c_i     (duty_c),
    .low_a_i      (low_a),
    .low_b_i      (low_b),
    .low_c_i      (low_c),
    .code_valid_i (code_valid),
    .duty_now_i   (duty_now),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // hall codes in clockwise rotation order
  function automatic logic [HallBits-1:0] rot_code(input int pos);
    logic [HallBits-1:0] c;
    case (pos)
      0:       c = 3'd5;
      1:       c = 3'd1;
      2:       c = 3'd3;
      3:       c = 3'd2;
      4:       c = 3'd6;
      default: c = 3'd4;
    endcase
    return c;
  endfunction

  task automatic push_event(input logic [HallBits-1:0] code);
    in_valid  <= 1'b1;
    hall_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic stop_events();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly proper rotation sequences, with glitch codes mixed in
  task automatic run_events(input int n, input int noise_pct);
    int                  left, burst, gap, pos, step;
    logic [HallBits-1:0] code;
    left = n;
    pos  = $urandom_range(0, 5);
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      step  = ($urandom_range(0, 9) == 0) ? 5 : 1;
      while (burst > 0 && left > 0) begin
        if ($urandom_range(0, 99) < noise_pct) begin
          code = HallBits'($urandom_range(0, 7));
        end else begin
          pos  = (pos + step) % 6;
          code = rot_code(pos);
        end
        push_event(code);
        burst--;
        left--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (left > 0 && gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    stop_events();
  endtask

  // result side: stall pattern of its own plus a few long hold-offs
  initial begin : receiver
    int mode, span, rcyc, hold;
    rcyc = 0;
    hold = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        rcyc++;
        if (out_valid && !out_stall) last_level = duty_now;
        if (rcyc == 1500 || rcyc == 3500 || rcyc == 6000) hold = HoldCycles;
        if (hold > 0) begin
          hold--;
          out_stall <= 1'b1;
        end else begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 30);
            2:       out_stall <= ($urandom_range(0, 9) == 0) ? !out_stall : out_stall;
            default: out_stall <= ($urandom_range(0, 99) < 70);
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    while (cyc < CycleLimit) begin
      @(posedge clk);
      cyc++;
    end
    $display("bldc_hall_commutation_ramp test failed");
    $finish;
  end

  initial begin : stimulus
    int                  p;
    int                  ival;
    logic [DutyBits-1:0] t;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset settings: invalid codes before any drive, then every code
    push_event(HallLow);
    push_event(HallHigh);
    for (p = 0; p < 6; p++) push_event(rot_code(p));
    push_event(HallLow);
    push_event(HallHigh);
    stop_events();

    // full target, fastest ramp
    wait_idle();
    write_reg(CfgTargetDuty, DutyMax);
    write_reg(CfgRampInterval, CfgDataBits'(0));
    for (p = 0; p < 6; p++) push_event(rot_code(p));
    push_event(HallHigh);
    stop_events();

    // direction change while a drive is held
    wait_idle();
    write_reg(CfgReverseDir, CfgDataBits'(1));
    push_event(HallLow);
    for (p = 0; p < 6; p++) push_event(rot_code(p));
    stop_events();

    run_events(150, 5);

    // descend below the level, then sit at target
    wait_idle();
    write_reg(CfgTargetDuty, last_level - DutyBits'(100));
    run_events(150, 5);
    wait_idle();
    write_reg(CfgTargetDuty, last_level);
    write_reg(CfgSpare, CfgDataBits'($urandom));
    run_events(80, 10);

    // counter left above a lowered interval has to wrap round
    wait_idle();
    write_reg(CfgTargetDuty, DutyMax);
    write_reg(CfgRampInterval, CfgDataBits'(200));
    run_events(120, 5);
    wait_idle();
    write_reg(CfgRampInterval, {8'($urandom), 8'd5});
    run_events(300, 5);

    wait_idle();
    write_reg(CfgRampInterval, CfgDataBits'(255));
    write_reg(CfgReverseDir, CfgDataBits'(0));
    run_events(100, 5);

    for (p = 0; p < 10; p++) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0:       t = DutyMax;
        1:       t = '0;
        2:       t = last_level + DutyBits'($urandom_range(0, 60)) - DutyBits'(30);
        default: t = DutyBits'($urandom);
      endcase
      ival = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 255);
      write_reg(CfgTargetDuty, t);
      write_reg(CfgReverseDir, CfgDataBits'($urandom));
      write_reg(CfgRampInterval, {8'($urandom), 8'(ival)});
      run_events(120, 8);
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("bldc_hall_commutation_ramp test passed");
    end else begin
      $display("bldc_hall_commutation_ramp test failed");
    end
    $finish;
  end

endmodule

// ===== bldc_hall_commutation_ramp.f =====
rtl/core/bhcr_pkg.sv
rtl/core/bhcr_commutator.sv
rtl/core/bldc_hall_commutation_ramp.sv
sim/bhcr_drive_checker.sv
sim/bldc_hall_commutation_ramp_tb.sv
